// ----- src/mavg_pkg.sv -----
// Shared constants and types for the moving average block.
// No dependencies; every module of the block but mavg_ram imports this package.
package mavg_pkg;

	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 12;

	// Port widths of the payload fields
	localparam int IN_BITS  = 12;
	localparam int AVG_BITS = 12;

	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int CNT_BITS  = $clog2(WINDOW + 1);
	localparam int POS_BITS  = $clog2(WINDOW);
	localparam int STEP_BITS = $clog2(SUM_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} mavg_state_t;

	typedef struct packed {
		logic load;     // take a new sample, update sum and start the divide
		logic step;     // one quotient bit
		logic publish;  // move the quotient into the output register
	} mavg_cmd_t;

	typedef struct packed {
		logic last_step;
	} mavg_stat_t;

endpackage

// ----- src/moving_average_with_warmup.sv -----
// Top level of the moving average block: controller plus datapath.
// Uses mavg_pkg, mavg_ctrl, mavg_datapath.
//
// Input channel: sample with in_valid / in_ready; a beat moves when both are
// high. Output channel: average with out_valid / out_ready, same rule.
// Each sample yields one average: the truncated mean of the last WINDOW
// samples, or of all samples so far during warm-up.
// Order: the sum update happens in the accept cycle, then a restoring
// divider takes one quotient bit per cycle for SUM_BITS (16) bits, and
// then the output register loads and out_valid rises. One item is in work
// at a time, so the input takes no new beat until the last average has
// been published; the bit-serial divider sets the pace.
// Reset clears the running sum, fill count, write position and the output
// valid; the ring entries are treated as zero until the ring has filled.
// When the receiver stalls, the finished average waits in the output
// register while the next sample is accepted and divided; that next result
// then holds in the divider until the output register is taken.
module moving_average_with_warmup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mavg_pkg::IN_BITS-1:0]  sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mavg_pkg::AVG_BITS-1:0] average
);

	import mavg_pkg::*;

	mavg_cmd_t  cmd;
	mavg_stat_t stat;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	mavg_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.sample (sample),
		.average(average)
	);

endmodule

// ----- src/mavg_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module mavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/mavg_datapath.sv -----
// Datapath: sample ring, running sum, fill count, write position,
// bit-serial restoring divider and the output register. Uses mavg_pkg, mavg_ram.
module mavg_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mavg_pkg::mavg_cmd_t          cmd,
	output mavg_pkg::mavg_stat_t         stat,
	input  logic [mavg_pkg::IN_BITS-1:0] sample,
	output logic [mavg_pkg::AVG_BITS-1:0] average
);

	import mavg_pkg::*;

	logic [SUM_BITS-1:0]    sum_q;
	logic [CNT_BITS-1:0]    fill_q;
	logic [POS_BITS-1:0]    pos_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [SUM_BITS-1:0]    dq_q;
	logic [CNT_BITS-1:0]    rem_q;
	logic [AVG_BITS-1:0]    average_q;

	logic [SAMPLE_BITS-1:0] s_val;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] old_val;
	logic                   full;
	logic [SUM_BITS-1:0]    sum_d;
	logic [CNT_BITS-1:0]    fill_d;
	logic [POS_BITS-1:0]    pos_d;
	logic [CNT_BITS:0]      trial;
	logic [CNT_BITS:0]      divisor;
	logic                   fits;

	mavg_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(pos_q),
		.wdata(s_val),
		.raddr(pos_q),
		.rdata(rd_data)
	);

	// Positions fill in order, so before the ring is full the entry at the
	// write position has never been written and counts as zero.
	assign s_val   = SAMPLE_BITS'(sample);
	assign full    = (fill_q == CNT_BITS'(WINDOW));
	assign old_val = full ? rd_data : '0;
	assign sum_d   = sum_q - SUM_BITS'(old_val) + SUM_BITS'(s_val);
	assign fill_d  = full ? fill_q : fill_q + CNT_BITS'(1);
	assign pos_d   = (pos_q == POS_BITS'(WINDOW - 1)) ? '0 : pos_q + POS_BITS'(1);

	assign trial   = {rem_q, dq_q[SUM_BITS-1]};
	assign divisor = {1'b0, fill_q};
	assign fits    = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
			pos_q  <= '0;
			step_q <= '0;
		end else if (cmd.load) begin
			sum_q  <= sum_d;
			fill_q <= fill_d;
			pos_q  <= pos_d;
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	// Shift dividend bits out the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dq_q  <= sum_d;
			rem_q <= '0;
		end else if (cmd.step) begin
			dq_q  <= {dq_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? CNT_BITS'(trial - divisor) : CNT_BITS'(trial);
		end
		if (cmd.publish) begin
			average_q <= AVG_BITS'(dq_q);
		end
	end

	assign stat.last_step = (step_q == STEP_BITS'(SUM_BITS - 1));
	assign average        = average_q;

endmodule

// ----- src/mavg_ctrl.sv -----
// Controller: sequences accept, divide and publish, and owns both handshakes.
// Uses mavg_pkg.
module mavg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mavg_pkg::mavg_cmd_t   cmd,
	input  mavg_pkg::mavg_stat_t  stat
);

	import mavg_pkg::*;

	mavg_state_t state_q;
	mavg_state_t state_d;
	logic        ovalid_q;
	logic        out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = !ovalid_q || out_ready;
	assign cmd.load    = in_valid && in_ready;
	assign cmd.step    = (state_q == ST_DIV);
	assign cmd.publish = (state_q == ST_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.last_step) state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold the quotient until the output register frees up
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;

endmodule
